/* design/rrq_pkg.sv */
`timescale 1ns / 1ps

package rrq_pkg;

  localparam int WORD_W        = 32;
  localparam int CODE_W        = 8;
  localparam int NCHAN         = 3;
  localparam int FRAC_BITS_DEF = 16;

  // One restoring step per code bit, plus two front stages.
  localparam int DIV_STAGES = CODE_W;
  localparam int LANE_LAT   = 2 + DIV_STAGES;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_RED    = 3'd0,
    REG_HIGH_RED   = 3'd1,
    REG_LOW_GREEN  = 3'd2,
    REG_HIGH_GREEN = 3'd3,
    REG_LOW_BLUE   = 3'd4,
    REG_HIGH_BLUE  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CMD_QUANT = 1'b0,
    CMD_RESID = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                     command;
    logic signed [WORD_W-1:0] hdr_red;
    logic signed [WORD_W-1:0] hdr_green;
    logic signed [WORD_W-1:0] hdr_blue;
    logic [CODE_W-1:0]        ldr_red;
    logic [CODE_W-1:0]        ldr_green;
    logic [CODE_W-1:0]        ldr_blue;
    logic                     last_pixel;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0]        code_red;
    logic [CODE_W-1:0]        code_green;
    logic [CODE_W-1:0]        code_blue;
    logic signed [WORD_W-1:0] resid_red;
    logic signed [WORD_W-1:0] resid_green;
    logic signed [WORD_W-1:0] resid_blue;
    logic                     last_out;
  } out_word_t;

endpackage

/* design/rrq_lane.sv */
`timescale 1ns / 1ps

// One colour channel: quantize through an 8-step pipelined restoring divider,
// residual through an exact divide-by-255 built from a digit sum and the
// modular inverse of 255. Both results leave the lane together.
module rrq_lane
  import rrq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [WORD_W-1:0] lo_i,
  input  logic signed [WORD_W-1:0] hi_i,
  input  logic signed [WORD_W-1:0] hdr_i,
  input  logic [CODE_W-1:0]        ldr_i,
  output logic [CODE_W-1:0]        code_o,
  output logic signed [WORD_W-1:0] resid_o
);

  localparam int RES_DLY = DIV_STAGES - 3;
  localparam logic [41:0] PU_BIAS = 42'd255 << 32;
  localparam logic signed [43:0] Q_BIAS = 44'sd4294967296;
  localparam logic signed [43:0] SAT_HI = 44'sd2147483647;
  localparam logic signed [43:0] SAT_LO = -44'sd2147483648;

  // stage 1
  logic signed [32:0] span_q, num_q;
  logic [CODE_W-1:0]  ldr_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      span_q <= $signed({hi_i[WORD_W-1], hi_i}) - $signed({lo_i[WORD_W-1], lo_i});
      num_q  <= $signed({hdr_i[WORD_W-1], hdr_i}) - $signed({lo_i[WORD_W-1], lo_i});
      ldr_q  <= ldr_i;
    end
  end

  // stage 2 feeds divider index 0 and the residual path
  logic [41:0]        rem_q  [DIV_STAGES+1];
  logic [32:0]        dsor_q [DIV_STAGES+1];
  logic [CODE_W-1:0]  qacc_q [DIV_STAGES+1];
  logic               zero_q [DIV_STAGES+1];
  logic               full_q [DIV_STAGES+1];

  logic signed [41:0] prod;
  logic [40:0]        pu_q;
  logic signed [32:0] num2_q;

  assign prod = 42'(span_q) * 42'($signed({1'b0, ldr_q}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (span_q <= 33'sd0) || (num_q <= 33'sd0);
      full_q[0] <= num_q >= span_q;
      rem_q[0]  <= 42'(num_q[31:0]) * 42'd510 + 42'(span_q[31:0]);
      dsor_q[0] <= {span_q[31:0], 1'b0};
      qacc_q[0] <= '0;
      pu_q      <= 41'($unsigned(prod) + PU_BIAS);
      num2_q    <= num_q;
    end
  end

  // restoring division of (510*num + span) by 2*span, one code bit a stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int SH = DIV_STAGES - 1 - k;
    logic [42:0] trial;

    assign trial = {1'b0, rem_q[k]} - (43'(dsor_q[k]) << SH);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= trial[42] ? rem_q[k] : trial[41:0];
        qacc_q[k+1] <= qacc_q[k] | (CODE_W'(!trial[42]) << SH);
        dsor_q[k+1] <= dsor_q[k];
        zero_q[k+1] <= zero_q[k];
        full_q[k+1] <= full_q[k];
      end
    end
  end

  assign code_o = zero_q[DIV_STAGES] ? '0 :
                  full_q[DIV_STAGES] ? {CODE_W{1'b1}} : qacc_q[DIV_STAGES];

  // residual stage 3: remainder mod 255 from the byte sum (256 = 1 mod 255)
  logic [10:0]        dsum;
  logic [8:0]         dsum1;
  logic [7:0]         rmod;
  logic [47:0]        pu_pad;
  logic [7:0]         r3_q;
  logic [40:0]        w3_q;
  logic signed [32:0] num3_q;

  assign pu_pad = {7'b0, pu_q};
  assign dsum   = 11'(pu_pad[7:0]) + 11'(pu_pad[15:8]) + 11'(pu_pad[23:16])
                + 11'(pu_pad[31:24]) + 11'(pu_pad[39:32]) + 11'(pu_pad[47:40]);
  assign dsum1  = 9'(dsum[10:8]) + 9'(dsum[7:0]);
  assign rmod   = (dsum1 >= 9'd255) ? 8'(dsum1 - 9'd255) : dsum1[7:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r3_q   <= rmod;
      w3_q   <= pu_q - 41'(rmod);
      num3_q <= num2_q;
    end
  end

  // stage 4: exact quotient, w / 255 = -w * (1 + 2^8 + ... + 2^40) mod 2^41
  logic [40:0]        tsum;
  logic [40:0]        q4_q;
  logic               rb4_q;
  logic signed [32:0] num4_q;

  assign tsum = w3_q + (w3_q << 8) + (w3_q << 16) + (w3_q << 24)
              + (w3_q << 32) + (w3_q << 40);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q4_q   <= 41'(~tsum + 41'd1);
      rb4_q  <= r3_q >= 8'd128;
      num4_q <= num3_q;
    end
  end

  // stage 5: subtract the dequantized term and saturate
  logic signed [43:0] term, res_w;
  logic signed [WORD_W-1:0] res_q [RES_DLY+1];

  assign term  = $signed({3'b0, q4_q}) - Q_BIAS + $signed({43'b0, rb4_q});
  assign res_w = $signed({{11{num4_q[32]}}, num4_q}) - term;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (res_w > SAT_HI) begin
        res_q[0] <= 32'sh7fffffff;
      end else if (res_w < SAT_LO) begin
        res_q[0] <= 32'sh80000000;
      end else begin
        res_q[0] <= res_w[WORD_W-1:0];
      end
    end
  end

  // hold the residual in step with the divider
  for (genvar j = 0; j < RES_DLY; j++) begin : g_rdly
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        res_q[j+1] <= res_q[j];
      end
    end
  end

  assign resid_o = res_q[RES_DLY];

endmodule

/* design/rgb_range_quantize_residual_core.sv */
`timescale 1ns / 1ps

// Per-pixel min/max 8-bit quantizer and residual unit. One pixel word is
// taken every cycle unless the output is stalled, and its result passes
// through 10 stages in each channel lane, set by the 8-step pipelined
// restoring divider, and then the merge register. The three channels run in
// parallel lanes. Command 0 returns codes with zero residuals, command 1
// returns residuals against the given codes with zero codes. The range
// registers must only be written while no pixel is in flight.
module rgb_range_quantize_residual_core
  import rrq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  localparam logic [WORD_W-1:0] ONE_FIX = WORD_W'(64'd1 << FRAC_BITS);

  logic signed [WORD_W-1:0] lo_q [NCHAN];
  logic signed [WORD_W-1:0] hi_q [NCHAN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCHAN; c++) begin
        lo_q[c] <= '0;
        hi_q[c] <= ONE_FIX;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_RED:    lo_q[0] <= cfg_data_i;
        REG_HIGH_RED:   hi_q[0] <= cfg_data_i;
        REG_LOW_GREEN:  lo_q[1] <= cfg_data_i;
        REG_HIGH_GREEN: hi_q[1] <= cfg_data_i;
        REG_LOW_BLUE:   lo_q[2] <= cfg_data_i;
        REG_HIGH_BLUE:  hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance the whole pipe unless the output word is held
  logic en;
  logic out_valid_q;
  out_word_t out_word_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  logic vld_q  [LANE_LAT];
  logic cmd_q  [LANE_LAT];
  logic last_q [LANE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LANE_LAT; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int s = 1; s < LANE_LAT; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_q[0]  <= in_word_i.command;
      last_q[0] <= in_word_i.last_pixel;
      for (int s = 1; s < LANE_LAT; s++) begin
        cmd_q[s]  <= cmd_q[s-1];
        last_q[s] <= last_q[s-1];
      end
    end
  end

  logic signed [WORD_W-1:0] hdr   [NCHAN];
  logic [CODE_W-1:0]        ldr   [NCHAN];
  logic [CODE_W-1:0]        code  [NCHAN];
  logic signed [WORD_W-1:0] resid [NCHAN];

  assign hdr[0] = in_word_i.hdr_red;
  assign hdr[1] = in_word_i.hdr_green;
  assign hdr[2] = in_word_i.hdr_blue;
  assign ldr[0] = in_word_i.ldr_red;
  assign ldr[1] = in_word_i.ldr_green;
  assign ldr[2] = in_word_i.ldr_blue;

  for (genvar c = 0; c < NCHAN; c++) begin : g_lane
    rrq_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .lo_i   (lo_q[c]),
      .hi_i   (hi_q[c]),
      .hdr_i  (hdr[c]),
      .ldr_i  (ldr[c]),
      .code_o (code[c]),
      .resid_o(resid[c])
    );
  end

  // merge: pick codes or residuals by command
  logic      resid_sel;
  out_word_t out_d;

  assign resid_sel = cmd_q[LANE_LAT-1] == CMD_RESID;

  always_comb begin
    out_d.code_red    = resid_sel ? '0 : code[0];
    out_d.code_green  = resid_sel ? '0 : code[1];
    out_d.code_blue   = resid_sel ? '0 : code[2];
    out_d.resid_red   = resid_sel ? resid[0] : '0;
    out_d.resid_green = resid_sel ? resid[1] : '0;
    out_d.resid_blue  = resid_sel ? resid[2] : '0;
    out_d.last_out    = last_q[LANE_LAT-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_word_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
